// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the same cycle
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent in this cycle, consequent in the next cycle
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cli_pkg.sv =====
package cli_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LVLS  = $clog2(DEPTH);
  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LIST   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_LISTED    = 3'd5
  } status_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic load_scan;
    logic step_scan;
    logic cmp;
  } cell_ctl_t;

endpackage

// ===== rtl/compacting_list_insert_delete_top.sv =====
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------
// in        | in_valid / in_stall  | in_kind, in_value
// out       | out_valid / out_stall| out_status, out_entry, out_last
//
// append writes one cell; delete compares in all cells, then shifts
// list sends one entry a cycle out of cell 0 while the output register is free
// output register frees when out_stall is low; a stall holds the sequencer
// rst_n clears the fill count, sequencer and output valid; words need no reset
// one item in flight at a time; in_stall is high until its last transfer is issued
`include "assert_macros.svh"

module compacting_list_insert_delete_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_kind,
  input  logic signed [31:0]        in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                out_status,
  output logic signed [31:0]        out_entry,
  output logic                      out_last
);
  import cli_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_APP, S_CMP, S_DEL, S_LIST} state_t;

  state_t    state_r, state_nxt;
  cnt_t      count_r, count_nxt;
  cnt_t      lidx_r, lidx_nxt;
  word_t     op_value_r, op_value_nxt;
  logic      out_valid_r, out_valid_nxt;
  status_t   out_status_r, out_status_nxt;
  word_t     out_entry_r, out_entry_nxt;
  logic      out_last_r, out_last_nxt;

  cell_ctl_t ctl;
  logic      app_do;
  logic      del_do;
  logic      out_free;
  logic      any_w;
  logic      is_last;

  word_t            word_w [DEPTH];
  word_t            scan_w [DEPTH];
  logic [DEPTH-1:0] match_w;
  logic [DEPTH-1:0] pfx_w;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t nw, ns;
    if (i < DEPTH - 1) begin : g_mid
      assign nw = word_w[i+1];
      assign ns = scan_w[i+1];
    end else begin : g_end
      assign nw = word_w[i];
      assign ns = scan_w[i];
    end
    cli_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .value    (op_value_r),
      .wr_en    (app_do && (count_r == CNT_W'(i))),
      .shift_en (del_do && pfx_w[i]),
      .in_range (CNT_W'(i) < count_r),
      .nxt_word (nw),
      .nxt_scan (ns),
      .word_o   (word_w[i]),
      .scan_o   (scan_w[i]),
      .match_o  (match_w[i])
    );
  end

  cli_prefix u_prefix (
    .match_i (match_w),
    .pfx_o   (pfx_w),
    .any_o   (any_w)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign is_last  = (lidx_r == CNT_W'(count_r - 1'b1));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lidx_nxt       = lidx_r;
    op_value_nxt   = op_value_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_last_nxt   = out_last_r;
    ctl            = '0;
    app_do         = 1'b0;
    del_do         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_value_nxt = in_value;
          lidx_nxt     = '0;
          priority if (in_kind == KIND_APPEND) begin
            state_nxt = S_APP;
          end else if (in_kind == KIND_DELETE) begin
            state_nxt = S_CMP;
          end else if (in_kind == KIND_LIST) begin
            state_nxt     = S_LIST;
            ctl.load_scan = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_APP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = '0;
          out_last_nxt  = 1'b1;
          if (count_r == CNT_W'(DEPTH)) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_INSERTED;
            app_do         = 1'b1;
            count_nxt      = CNT_W'(count_r + 1'b1);
          end
          state_nxt = S_IDLE;
        end
      end
      S_CMP: begin
        ctl.cmp   = 1'b1;
        state_nxt = S_DEL;
      end
      S_DEL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = '0;
          out_last_nxt  = 1'b1;
          if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
          end else if (any_w) begin
            out_status_nxt = ST_DELETED;
            del_do         = 1'b1;
            count_nxt      = CNT_W'(count_r - 1'b1);
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_status_nxt = ST_EMPTY;
            out_entry_nxt  = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            out_status_nxt = ST_LISTED;
            out_entry_nxt  = scan_w[0];
            out_last_nxt   = is_last;
            ctl.step_scan  = 1'b1;
            lidx_nxt       = CNT_W'(lidx_r + 1'b1);
            if (is_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lidx_r       <= lidx_nxt;
    op_value_r   <= op_value_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_last   = out_last_r;

  `CHK_ALWAYS(a_count_range, count_r <= CNT_W'(DEPTH), "fill count above depth")
  `CHK_IMPL(a_single_last, out_valid_r && out_status_r != ST_LISTED,
            out_last_r && out_entry_r == '0, "status result not single")
  `CHK_NEXT(a_busy_after,
            in_valid && !in_stall &&
            (in_kind == KIND_APPEND || in_kind == KIND_DELETE || in_kind == KIND_LIST),
            in_stall, "sequencer idle after transfer")
  `CHK_NEXT(a_count_step, 1'b1,
            count_r == $past(count_r) || count_r == CNT_W'($past(count_r) + 1'b1) ||
            count_r == CNT_W'($past(count_r) - 1'b1), "fill count jumped")

endmodule

// ===== rtl/cli_cell.sv =====
module cli_cell (
  input  logic              clk,
  input  cli_pkg::cell_ctl_t ctl,
  input  cli_pkg::word_t    value,
  input  logic              wr_en,
  input  logic              shift_en,
  input  logic              in_range,
  input  cli_pkg::word_t    nxt_word,
  input  cli_pkg::word_t    nxt_scan,
  output cli_pkg::word_t    word_o,
  output cli_pkg::word_t    scan_o,
  output logic              match_o
);
  import cli_pkg::*;

  word_t word_r;
  word_t scan_r;
  logic  match_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_r <= value;
    end else if (shift_en) begin
      word_r <= nxt_word;
    end
    if (ctl.load_scan) begin
      scan_r <= word_r;
    end else if (ctl.step_scan) begin
      scan_r <= nxt_scan;
    end
    if (ctl.cmp) begin
      match_r <= in_range && (word_r == value);
    end
  end

  assign word_o  = word_r;
  assign scan_o  = scan_r;
  assign match_o = match_r;

endmodule

// ===== rtl/cli_prefix.sv =====
module cli_prefix (
  input  logic [cli_pkg::DEPTH-1:0] match_i,
  output logic [cli_pkg::DEPTH-1:0] pfx_o,
  output logic                      any_o
);
  import cli_pkg::*;

  // log-depth prefix or: bit i set when some cell at or below i matched
  logic [DEPTH-1:0] lvl_w [LVLS+1];

  always_comb begin
    lvl_w[0] = match_i;
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << l)) begin
          lvl_w[l+1][i] = lvl_w[l][i] | lvl_w[l][i - (1 << l)];
        end else begin
          lvl_w[l+1][i] = lvl_w[l][i];
        end
      end
    end
  end

  assign pfx_o = lvl_w[LVLS];
  assign any_o = lvl_w[LVLS][DEPTH-1];

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cli_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 196;
  localparam int QUIET_TAIL = 30;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [1:0] kind;
    word_t value;
  } op_t;

  typedef struct {
    status_t status;
    word_t entry;
    logic last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic signed [31:0] out_entry;
  logic out_last;

  op_t op_queue[$];
  word_t shadow[$];
  int staged;

  result_t pending_results[$];
  word_t list_mem[DEPTH];
  int list_len;

  int failures;
  logic quiet = 1'b0;
  op_t next_op;
  int in_gap, out_gap, in_idle_pct, out_idle_pct, cyc;
  result_t want;
  int stuck;

  compacting_list_insert_delete_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_entry(out_entry),
    .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void queue_result(status_t status, word_t entry, logic last);
    result_t r;
    r.status = status;
    r.entry = entry;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_to_list(logic [1:0] kind, word_t value);
    int hit;
    hit = -1;
    case (kind)
      KIND_APPEND: begin
        if (list_len >= DEPTH) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          list_mem[list_len] = value;
          list_len++;
          queue_result(ST_INSERTED, '0, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (list_len == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (list_mem[i] == value) begin
              hit = i;
              break;
            end
          end
          if (hit < 0) begin
            queue_result(ST_NOT_FOUND, '0, 1'b1);
          end else begin
            for (int i = hit; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
            list_len--;
            queue_result(ST_DELETED, '0, 1'b1);
          end
        end
      end
      KIND_LIST: begin
        if (list_len == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            queue_result(ST_LISTED, list_mem[i], i == list_len - 1);
        end
      end
      default: ;
    endcase
  endfunction

  // stimulus side keeps its own view of the list to steer deletes at held words
  function automatic void stage(logic [1:0] kind, word_t value);
    op_t op;
    op.kind = kind;
    op.value = value;
    op_queue.push_back(op);
    if (kind != KIND_UNUSED) staged++;
    if (kind == KIND_APPEND && shadow.size() < DEPTH) shadow.push_back(value);
    if (kind == KIND_DELETE) begin
      for (int i = 0; i < shadow.size(); i++) begin
        if (shadow[i] == value) begin
          shadow.delete(i);
          break;
        end
      end
    end
  endfunction

  function automatic word_t pick_value();
    word_t v;
    case ($urandom_range(0, 3))
      0: v = word_t'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = word_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic word_t held_value();
    return shadow[$urandom_range(0, shadow.size() - 1)];
  endfunction

  initial begin
    int target, round, r, n;
    staged = 0;

    stage(KIND_LIST, '0);
    stage(KIND_DELETE, 5);
    stage(KIND_UNUSED, '0);
    stage(KIND_APPEND, WORD_MIN);
    stage(KIND_APPEND, WORD_MAX);
    stage(KIND_APPEND, '0);
    stage(KIND_APPEND, -1);
    stage(KIND_APPEND, 7);
    stage(KIND_APPEND, '0);
    stage(KIND_APPEND, 7);
    stage(KIND_LIST, '0);
    stage(KIND_DELETE, 12345);
    stage(KIND_DELETE, '0);
    stage(KIND_LIST, '0);
    stage(KIND_DELETE, WORD_MIN);
    stage(KIND_DELETE, 7);
    stage(KIND_DELETE, 7);
    stage(KIND_UNUSED, -1);
    stage(KIND_LIST, '0);
    stage(KIND_DELETE, -1);
    stage(KIND_DELETE, '0);
    stage(KIND_DELETE, WORD_MAX);
    stage(KIND_LIST, '0);
    stage(KIND_DELETE, '0);

    target = staged + RANDOM_ITEMS;
    round = 0;
    while (staged < target) begin
      case (round % 4)
        1: begin
          // fill to full, then overflow
          while (shadow.size() < DEPTH) begin
            if ($urandom_range(0, 15) == 0) stage(KIND_LIST, word_t'($urandom));
            else stage(KIND_APPEND, pick_value());
          end
          stage(KIND_APPEND, pick_value());
          stage(KIND_APPEND, pick_value());
          stage(KIND_LIST, '0);
        end
        3: begin
          // drain to empty
          while (shadow.size() > 0) begin
            if ($urandom_range(0, 7) == 0) stage(KIND_LIST, '0);
            else stage(KIND_DELETE, held_value());
          end
          stage(KIND_DELETE, pick_value());
          stage(KIND_LIST, '0);
        end
        default: begin
          n = 0;
          while (n < 30 && staged < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
              stage(KIND_APPEND, pick_value());
            end else if (r < 75) begin
              if (shadow.size() > 0 && $urandom_range(0, 3) != 0)
                stage(KIND_DELETE, held_value());
              else
                stage(KIND_DELETE, pick_value());
            end else if (r < 92) begin
              stage(KIND_LIST, word_t'($urandom));
            end else begin
              stage(KIND_UNUSED, word_t'($urandom));
            end
            n++;
          end
        end
      endcase
      round++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= '0;
      in_value <= '0;
      quiet <= 1'b0;
      list_len = 0;
      in_gap = 0;
      in_idle_pct = 0;
      cyc = 0;
    end else begin
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: in_idle_pct = 0;
          1: in_idle_pct = 15;
          default: in_idle_pct = 40;
        endcase
      end
      if (in_valid && !in_stall) apply_to_list(in_kind, in_value);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (op_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          next_op = op_queue.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_op.kind;
          in_value <= next_op.value;
        end
      end
      quiet <= op_queue.size() < QUIET_TAIL;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
      out_idle_pct = 0;
      failures = 0;
    end else begin
      if (cyc % 64 == 32) begin
        case ($urandom_range(0, 2))
          0: out_idle_pct = 0;
          1: out_idle_pct = 20;
          default: out_idle_pct = 45;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transfer: status %0d entry %0d last %0d",
                 out_status, out_entry, out_last);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            failures++;
          end
          if (out_entry !== want.entry) begin
            $error("entry: expected %0d, actual %0d", want.entry, out_entry);
            failures++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            failures++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results outstanding",
               STUCK_LIMIT, pending_results.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cli_pkg.sv
rtl/cli_cell.sv
rtl/cli_prefix.sv
rtl/compacting_list_insert_delete_top.sv
tb/sv/testbench.sv
